// ===== hw/rtl/int_to_decimal_string_core_macros.svh =====
// Assertion macros shared by the converter RTL.
// Each check is sampled on the rising clock edge and is held off while reset is asserted.
`ifndef INT_TO_DECIMAL_STRING_CORE_MACROS_SVH
`define INT_TO_DECIMAL_STRING_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define I2DS_ASSERT(label, clk_sig, rst_sig, prop) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) prop) \
        else $error("i2ds assertion failed");
`define I2DS_ASSERT_NEVER(label, clk_sig, rst_sig, expr) \
    `I2DS_ASSERT(label, clk_sig, rst_sig, !(expr))
`else
`define I2DS_ASSERT(label, clk_sig, rst_sig, prop)
`define I2DS_ASSERT_NEVER(label, clk_sig, rst_sig, expr)
`endif
`endif

// ===== hw/rtl/i2ds_pkg.sv =====
package i2ds_pkg;

    // Width of the signed input value.
    localparam int DATA_WIDTH = 32;

    // Decimal digits needed for a magnitude below 2^DATA_WIDTH
    // (1233/4096 approximates log10(2)).
    localparam int NUM_DIGITS = (DATA_WIDTH * 1233) / 4096 + 1;
    localparam int DIGIT_IDX_W = $clog2(NUM_DIGITS);
    localparam int BCD_W = NUM_DIGITS * 4;

    // The double-dabble converter takes four magnitude bits per cycle.
    localparam int DABBLE_BITS = 4;
    localparam int STEP_COUNT = (DATA_WIDTH + DABBLE_BITS - 1) / DABBLE_BITS;
    localparam int STEP_W = $clog2(STEP_COUNT);
    localparam int MAG_PAD_W = STEP_COUNT * DABBLE_BITS;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam int CHAR_W = 7;
    localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'd48;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'd45;

    // A classified value waiting for conversion.
    typedef struct packed {
        logic                  negative;
        logic [DATA_WIDTH-1:0] magnitude;
    } item_t;

    // A converted value: sign and packed BCD digits, most significant digit on top.
    typedef struct packed {
        logic             negative;
        logic [BCD_W-1:0] bcd;
    } digits_t;

endpackage

// ===== hw/rtl/i2ds_front.sv =====
module i2ds_front
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [i2ds_pkg::DATA_WIDTH-1:0] value,
    input  logic                                q_full,
    output logic                                push,
    output i2ds_pkg::item_t                     item
);

    logic            fr_valid_reg;
    logic            fr_valid_next;
    i2ds_pkg::item_t fr_item_reg;
    i2ds_pkg::item_t fr_item_next;
    logic            accept;
    logic [i2ds_pkg::DATA_WIDTH-1:0] raw;

    assign in_stall = fr_valid_reg && q_full;
    assign accept   = in_valid && !in_stall;
    assign push     = fr_valid_reg && !q_full;
    assign item     = fr_item_reg;
    assign raw      = $unsigned(value);

    always_comb
    begin
        fr_item_next = fr_item_reg;
        if (accept)
        begin
            fr_item_next.negative  = raw[i2ds_pkg::DATA_WIDTH-1];
            // Taken as unsigned, so the most negative value gives 2^(DATA_WIDTH-1).
            fr_item_next.magnitude = raw[i2ds_pkg::DATA_WIDTH-1] ? (~raw + 1'b1) : raw;
        end
    end

    always_comb
    begin
        if (accept)
        begin
            fr_valid_next = 1'b1;
        end
        else if (push)
        begin
            fr_valid_next = 1'b0;
        end
        else
        begin
            fr_valid_next = fr_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fr_valid_reg <= 1'b0;
        end
        else
        begin
            fr_valid_reg <= fr_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fr_item_reg <= fr_item_next;
    end

endmodule

// ===== hw/rtl/i2ds_queue.sv =====
`include "int_to_decimal_string_core_macros.svh"

module i2ds_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  i2ds_pkg::item_t push_item,
    output logic            full,
    input  logic            pop,
    output logic            q_valid,
    output i2ds_pkg::item_t q_item
);

    i2ds_pkg::item_t                entry_reg [i2ds_pkg::QUEUE_DEPTH];
    logic [i2ds_pkg::QPTR_W-1:0]    wr_ptr_reg;
    logic [i2ds_pkg::QPTR_W-1:0]    wr_ptr_next;
    logic [i2ds_pkg::QPTR_W-1:0]    rd_ptr_reg;
    logic [i2ds_pkg::QPTR_W-1:0]    rd_ptr_next;
    logic [i2ds_pkg::QCNT_W-1:0]    count_reg;
    logic [i2ds_pkg::QCNT_W-1:0]    count_next;
    logic                           do_push;
    logic                           do_pop;

    assign full    = (count_reg == i2ds_pkg::QCNT_W'(i2ds_pkg::QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_item  = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && q_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == i2ds_pkg::QPTR_W'(i2ds_pkg::QUEUE_DEPTH - 1))
                        ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == i2ds_pkg::QPTR_W'(i2ds_pkg::QUEUE_DEPTH - 1))
                        ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    `I2DS_ASSERT(a_count_bound, clk, rst_n, count_reg <= i2ds_pkg::QCNT_W'(i2ds_pkg::QUEUE_DEPTH))
    `I2DS_ASSERT(a_no_push_when_full, clk, rst_n, push |-> !full)

endmodule

// ===== hw/rtl/i2ds_conv.sv =====
`include "int_to_decimal_string_core_macros.svh"

module i2ds_conv
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  i2ds_pkg::item_t   q_item,
    output logic              pop,
    output logic              res_valid,
    input  logic              take,
    output i2ds_pkg::digits_t res
);

    typedef enum logic [2:0] {
        CV_IDLE = 3'b001,
        CV_RUN  = 3'b010,
        CV_DONE = 3'b100
    } conv_state_t;

    conv_state_t                        state_reg;
    conv_state_t                        state_next;
    logic [i2ds_pkg::STEP_W-1:0]        cnt_reg;
    logic [i2ds_pkg::STEP_W-1:0]        cnt_next;
    logic [i2ds_pkg::MAG_PAD_W-1:0]     mag_reg;
    logic [i2ds_pkg::MAG_PAD_W-1:0]     mag_next;
    logic [i2ds_pkg::BCD_W-1:0]         bcd_reg;
    logic [i2ds_pkg::BCD_W-1:0]         bcd_next;
    logic                               neg_reg;
    logic                               neg_next;
    logic [i2ds_pkg::BCD_W-1:0]         work;

    assign res_valid    = (state_reg == CV_DONE);
    assign res.negative = neg_reg;
    assign res.bcd      = bcd_reg;

    // Four shift-and-add-3 steps per cycle, top magnitude bits first.
    always_comb
    begin
        work = bcd_reg;
        for (int b = 0; b < i2ds_pkg::DABBLE_BITS; b++)
        begin
            for (int d = 0; d < i2ds_pkg::NUM_DIGITS; d++)
            begin
                if (work[d*4 +: 4] >= 4'd5)
                begin
                    work[d*4 +: 4] = work[d*4 +: 4] + 4'd3;
                end
            end
            work = {work[i2ds_pkg::BCD_W-2:0], mag_reg[i2ds_pkg::MAG_PAD_W-1-b]};
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        mag_next   = mag_reg;
        bcd_next   = bcd_reg;
        neg_next   = neg_reg;
        pop        = 1'b0;
        case (state_reg)
            CV_IDLE:
            begin
                if (q_valid)
                begin
                    pop        = 1'b1;
                    mag_next   = i2ds_pkg::MAG_PAD_W'(q_item.magnitude);
                    neg_next   = q_item.negative;
                    bcd_next   = '0;
                    cnt_next   = '0;
                    state_next = CV_RUN;
                end
            end
            CV_RUN:
            begin
                bcd_next = work;
                mag_next = mag_reg << i2ds_pkg::DABBLE_BITS;
                if (cnt_reg == i2ds_pkg::STEP_W'(i2ds_pkg::STEP_COUNT - 1))
                begin
                    state_next = CV_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            CV_DONE:
            begin
                if (take)
                begin
                    state_next = CV_IDLE;
                end
            end
            default:
            begin
                state_next = CV_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CV_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        bcd_reg <= bcd_next;
        neg_reg <= neg_next;
    end

    `I2DS_ASSERT(a_done_holds, clk, rst_n, (state_reg == CV_DONE) && !take |=> (state_reg == CV_DONE))

endmodule

// ===== hw/rtl/i2ds_emit.sv =====
`include "int_to_decimal_string_core_macros.svh"

module i2ds_emit
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          res_valid,
    input  i2ds_pkg::digits_t             res,
    output logic                          take,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [i2ds_pkg::CHAR_W-1:0]   character,
    output logic                          last
);

    logic                                busy_reg;
    logic                                busy_next;
    logic                                neg_pend_reg;
    logic                                neg_pend_next;
    logic [i2ds_pkg::DIGIT_IDX_W-1:0]    idx_reg;
    logic [i2ds_pkg::DIGIT_IDX_W-1:0]    idx_next;
    logic [3:0]                          digit_reg [i2ds_pkg::NUM_DIGITS];
    logic [i2ds_pkg::DIGIT_IDX_W-1:0]    lead;
    logic                                out_valid_reg;
    logic                                out_valid_next;
    logic [i2ds_pkg::CHAR_W-1:0]         character_reg;
    logic [i2ds_pkg::CHAR_W-1:0]         character_next;
    logic                                last_reg;
    logic                                last_next;
    logic                                advance;
    logic [3:0]                          cur_digit;
    logic                                out_is_minus;
    logic                                out_is_digit;

    assign take      = res_valid && !busy_reg;
    assign advance   = busy_reg && (!out_valid_reg || !out_stall);
    assign cur_digit = digit_reg[idx_reg];
    assign out_valid = out_valid_reg;
    assign character = character_reg;
    assign last      = last_reg;

    assign out_is_minus = (character_reg == i2ds_pkg::CHAR_MINUS);
    assign out_is_digit = (character_reg >= i2ds_pkg::CHAR_ZERO)
                       && (character_reg <= i2ds_pkg::CHAR_ZERO + 7'd9);

    // Highest nonzero digit; a zero value starts and ends at digit zero.
    always_comb
    begin
        lead = '0;
        for (int i = 0; i < i2ds_pkg::NUM_DIGITS; i++)
        begin
            if (res.bcd[i*4 +: 4] != 4'd0)
            begin
                lead = i2ds_pkg::DIGIT_IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        busy_next      = busy_reg;
        neg_pend_next  = neg_pend_reg;
        idx_next       = idx_reg;
        character_next = character_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (take)
        begin
            busy_next     = 1'b1;
            neg_pend_next = res.negative;
            idx_next      = lead;
        end
        else if (advance)
        begin
            out_valid_next = 1'b1;
            if (neg_pend_reg)
            begin
                character_next = i2ds_pkg::CHAR_MINUS;
                last_next      = 1'b0;
                neg_pend_next  = 1'b0;
            end
            else
            begin
                character_next = i2ds_pkg::CHAR_ZERO + i2ds_pkg::CHAR_W'(cur_digit);
                last_next      = (idx_reg == '0);
                if (idx_reg == '0)
                begin
                    busy_next = 1'b0;
                end
                else
                begin
                    idx_next = idx_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            neg_pend_reg  <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
            neg_pend_reg  <= neg_pend_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        character_reg <= character_next;
        last_reg      <= last_next;
        if (take)
        begin
            for (int i = 0; i < i2ds_pkg::NUM_DIGITS; i++)
            begin
                digit_reg[i] <= res.bcd[i*4 +: 4];
            end
        end
    end

    `I2DS_ASSERT(a_minus_not_last, clk, rst_n, out_valid_reg && out_is_minus |-> !last_reg)
    `I2DS_ASSERT(a_char_legal, clk, rst_n, out_valid_reg && !out_is_minus |-> out_is_digit)

endmodule

// ===== hw/rtl/int_to_decimal_string_core.sv =====
// Signed integer to ASCII decimal text. Each input beat carries one signed
// two's complement value; the block answers with its decimal text, one ASCII
// character per output beat, most significant digit first, with a leading '-'
// for negative values, no leading zeros, and a single '0' for zero. The last
// beat of each value carries last = 1. The most negative value converts
// correctly through its unsigned magnitude. A front stage takes the beat and
// forms sign and magnitude, a two-entry queue follows, and the back part runs
// a double-dabble converter (four bits per cycle) ahead of a character
// emitter. Converter and emitter overlap: the converter loads a value from
// the queue, runs eight steps and hands the digits over, and the emitter then
// loads them and puts out one character at a time while the converter works
// on the next value. The input stall goes high only when the front register
// is full and the queue is full.
module int_to_decimal_string_core
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic signed [i2ds_pkg::DATA_WIDTH-1:0] value,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic [i2ds_pkg::CHAR_W-1:0]            character,
    output logic                                   last
);

    // Front to queue.
    logic              push;
    logic              q_full;
    i2ds_pkg::item_t   push_item;

    // Queue to converter.
    logic              q_valid;
    logic              pop;
    i2ds_pkg::item_t   q_item;

    // Converter to emitter.
    logic              res_valid;
    logic              take;
    i2ds_pkg::digits_t res;

    i2ds_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .value    (value),
        .q_full   (q_full),
        .push     (push),
        .item     (push_item)
    );

    i2ds_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_item    (q_item)
    );

    i2ds_conv u_conv
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .pop       (pop),
        .res_valid (res_valid),
        .take      (take),
        .res       (res)
    );

    // The emitter owns the output register, so a last character still waiting
    // there does not keep the converter from handing over the next value.
    i2ds_emit u_emit
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .take      (take),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .character (character),
        .last      (last)
    );

endmodule

// ===== tb/sv/int_to_decimal_string_core_tb_pkg.sv =====
package int_to_decimal_string_core_tb_pkg;

    import i2ds_pkg::*;

    // One character of decimal text as it should leave the block.
    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              last;
    } text_char_t;

    class decimal_text_scoreboard;

        text_char_t  pending_chars[$];
        int unsigned mismatch_count;

        // Spell an accepted value in decimal and queue its characters.
        function void note_value(logic [DATA_WIDTH-1:0] v);
            logic [DATA_WIDTH-1:0] magnitude;
            logic [3:0]            digits[$];
            text_char_t            c;
            // Unsigned negation, so the most negative value keeps its magnitude.
            magnitude = v[DATA_WIDTH-1] ? -v : v;
            do
            begin
                digits.push_front(4'(magnitude % 10));
                magnitude = magnitude / 10;
            end
            while (magnitude != 0);
            if (v[DATA_WIDTH-1])
            begin
                c.character = CHAR_MINUS;
                c.last = 1'b0;
                pending_chars.push_back(c);
            end
            foreach (digits[i])
            begin
                c.character = CHAR_ZERO + CHAR_W'(digits[i]);
                c.last = (i == digits.size() - 1);
                pending_chars.push_back(c);
            end
        endfunction

        // Compare one output beat with the oldest queued character.
        function void check_char(logic [CHAR_W-1:0] character, logic last);
            text_char_t want;
            if (pending_chars.size() == 0)
            begin
                $error("character: no value pending, got %0d (last %0d)", character, last);
                mismatch_count++;
                return;
            end
            want = pending_chars.pop_front();
            if (character !== want.character)
            begin
                $error("character: expected %0d, got %0d", want.character, character);
                mismatch_count++;
            end
            if (last !== want.last)
            begin
                $error("last: expected %0d, got %0d", want.last, last);
                mismatch_count++;
            end
        endfunction

    endclass

endpackage

// ===== tb/sv/int_to_decimal_string_core_tb.sv =====
module int_to_decimal_string_core_tb;

    import i2ds_pkg::*;
    import int_to_decimal_string_core_tb_pkg::*;

    // Run length and limits. The slowest correct run is roughly 300 values,
    // each of eleven characters, each character waiting out the longest random
    // stall, plus sender gaps and one long hold-off. The watchdog limit
    // CYCLE_LIMIT is set far above that.
    localparam int unsigned RANDOM_ITEMS = 250;
    localparam int unsigned PRESSURE_AT  = 100;
    localparam int unsigned LONG_HOLD    = 300;
    localparam int unsigned QUIET_TAIL   = 40;
    localparam int unsigned DRAIN_CYCLES = 40;
    localparam int unsigned CYCLE_LIMIT  = 200000;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [DATA_WIDTH-1:0] value = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [CHAR_W-1:0]     character;
    logic                  last;

    // Idling is switched off in calm windows and in the tail of the run.
    logic quiet = 1'b0;
    // Raised by the sender side to ask the receiver for one long hold-off.
    logic hold_request = 1'b0;

    decimal_text_scoreboard board;

    int_to_decimal_string_core i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .character (character),
        .last      (last)
    );

    // Clock, and a single reset pulse at the start of the run.
    initial
    begin
        board = new();
        clk = 1'b0;
        rst_n = 1'b0;
        fork
            forever #2 clk = ~clk;
        join_none
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Offer one value and hold it until the block takes the beat. All
    // handshake signals are sampled right after the rising edge, before any
    // register in the block has updated, so the sampled values are the ones
    // the block saw at that edge. Before the value goes out there may be a
    // random gap, during which the payload carries a random word as noise.
    task automatic send_value(input logic [DATA_WIDTH-1:0] v);
        if (!quiet && $urandom_range(3, 0) == 0)
        begin
            in_valid <= 1'b0;
            value <= $urandom;
            repeat ($urandom_range(9, 1)) @(posedge clk);
        end
        in_valid <= 1'b1;
        value <= v;
        do
            @(posedge clk);
        while (in_stall);
        board.note_value(v);
    endtask

    // Receiver side: checks every accepted character and drives out_stall.
    // It honors one long hold-off request, counting the cycles itself, and
    // otherwise stalls in short random bursts unless the run is quiet.
    initial
    begin : receiver
        int unsigned stall_left;
        int unsigned hold_left;
        bit          hold_taken;
        stall_left = 0;
        hold_left = 0;
        hold_taken = 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
                board.check_char(character, last);
            if (hold_request && !hold_taken)
            begin
                hold_left = LONG_HOLD;
                hold_taken = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (!quiet && $urandom_range(4, 0) == 0)
            begin
                stall_left = $urandom_range(9, 1) - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Stimulus, drain and verdict.
    initial
    begin : stimulus
        logic [DATA_WIDTH-1:0] directed_values[$];
        logic [DATA_WIDTH-1:0] r;
        int unsigned           k;
        // Directed values: zero, single digits of both signs, the decade
        // boundaries where the digit count changes, the largest value, the
        // most negative value and its neighbor, and alternating bit patterns.
        directed_values = '{
            32'd0, 32'd1, -32'd1, 32'd9, -32'd9, 32'd10, -32'd10, 32'd99,
            32'd100, 32'd999999999, 32'd1000000000, -32'd999999999,
            -32'd1000000000, 32'd1000000009, 32'h7fff_ffff, 32'h8000_0000,
            32'h8000_0001, 32'h5555_5555, 32'haaaa_aaaa, 32'd123456789,
            -32'd123456789, 32'd2000000000, 32'd5
        };
        wait (rst_n);
        @(posedge clk);
        foreach (directed_values[i])
            send_value(directed_values[i]);

        // Random values. Shifting a random word right by a random amount
        // spreads the digit counts evenly, and the random sign covers both
        // branches; now and then a full-width word goes in as it is.
        for (k = 0; k < RANDOM_ITEMS; k++)
        begin
            if (k == PRESSURE_AT)
                hold_request <= 1'b1;
            // A calm window in the middle, and a quiet tail at the end.
            if (k == 60 || k == RANDOM_ITEMS - QUIET_TAIL)
                quiet <= 1'b1;
            else if (k == 90)
                quiet <= 1'b0;
            if ($urandom_range(7, 0) == 0)
                r = $urandom;
            else
            begin
                r = $urandom >> $urandom_range(31, 0);
                if ($urandom_range(1, 0) == 1)
                    r = -r;
            end
            send_value(r);
        end
        in_valid <= 1'b0;

        // Wait for every queued character, then give the block time to show
        // any stray beat before the verdict.
        while (board.pending_chars.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.mismatch_count == 0)
            $display("int_to_decimal_string_core regression: pass");
        else
            $display("int_to_decimal_string_core regression: fail");
        $finish;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial
    begin : watchdog
        int unsigned cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("int_to_decimal_string_core regression: fail");
        $finish;
    end

endmodule

// ===== int_to_decimal_string_core.f =====
+incdir+hw/rtl
hw/rtl/i2ds_pkg.sv
hw/rtl/i2ds_front.sv
hw/rtl/i2ds_queue.sv
hw/rtl/i2ds_conv.sv
hw/rtl/i2ds_emit.sv
hw/rtl/int_to_decimal_string_core.sv
tb/sv/int_to_decimal_string_core_tb_pkg.sv
tb/sv/int_to_decimal_string_core_tb.sv
